// ===== sv/wppcd_pkg.sv =====
// Shared types and constants for the windowed peak-to-peak contact detector.
package wppcd_pkg;

	localparam int unsigned LEG_W    = 3;
	localparam int unsigned VAL_W    = 16;
	localparam int unsigned MASK_W   = 6;
	localparam int unsigned CFG_IW   = 1;
	// legs at or above this index have no enable bit
	localparam int unsigned MASK_LEGS = 6;

	typedef enum logic [CFG_IW-1:0] {
		CFG_THRESHOLD = 1'b0,
		CFG_LEG_MASK  = 1'b1
	} cfg_idx_t;

	typedef enum logic {
		OP_PUSH  = 1'b0,
		OP_CLEAR = 1'b1
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DECIDE = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_DRAIN  = 5'b01000,
		ST_OUT    = 5'b10000
	} state_t;

	typedef struct packed {
		logic load;    // capture the input item
		logic decide;  // push / clear, start of window walk
		logic scan;    // issue one window read
		logic emit;    // load the result register
	} ctl_cmd_t;

	typedef struct packed {
		logic eval_go;    // item needs a min/max walk
		logic scan_last;  // current read is the last one of the window
		logic out_busy;   // result register holds an item not yet taken
	} dp_sts_t;

endpackage

// ===== sv/wppcd_ctrl.sv =====
// Controller state machine: sequences capture, push, window walk and result load.
module wppcd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  wppcd_pkg::dp_sts_t  sts,
	output wppcd_pkg::ctl_cmd_t cmd
);
	import wppcd_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		in_stall   = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = sts.eval_go ? ST_SCAN : ST_OUT;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last read word folds into min/max here
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/wppcd_dp.sv =====
// Datapath: config registers, per-leg window memory and pointers, min/max walk, result register.
module wppcd_dp #(
	parameter int unsigned WINDOW_DEPTH = 16,
	parameter int unsigned LEG_COUNT    = 6,
	parameter int unsigned SAMPLE_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [wppcd_pkg::CFG_IW-1:0]        cfg_index,
	input  logic [wppcd_pkg::VAL_W-1:0]         cfg_data,
	input  logic                                operation,
	input  logic [wppcd_pkg::LEG_W-1:0]         leg,
	input  logic [wppcd_pkg::VAL_W-1:0]         sample,
	input  logic                                out_stall,
	input  wppcd_pkg::ctl_cmd_t                 cmd,
	output wppcd_pkg::dp_sts_t                  sts,
	output logic                                out_valid,
	output logic [wppcd_pkg::LEG_W-1:0]         out_leg,
	output logic                                accepted,
	output logic                                contact,
	output logic [wppcd_pkg::VAL_W-1:0]         window_min,
	output logic [wppcd_pkg::VAL_W-1:0]         window_max,
	output logic                                evaluated
);
	import wppcd_pkg::*;

	// only legs that can be enabled keep state
	localparam int unsigned NS   = (LEG_COUNT < MASK_LEGS) ? LEG_COUNT : MASK_LEGS;
	localparam int unsigned LIW  = (NS > 1) ? $clog2(NS) : 1;
	localparam int unsigned SW   = (SAMPLE_BITS < VAL_W) ? SAMPLE_BITS : VAL_W;
	localparam int unsigned SLW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int unsigned FW   = $clog2(WINDOW_DEPTH + 1);
	localparam int unsigned MD   = NS * WINDOW_DEPTH;
	localparam int unsigned AW   = (MD > 1) ? $clog2(MD) : 1;
	localparam logic [LEG_W:0]   NS_V   = (LEG_W + 1)'(NS);
	localparam logic [SLW-1:0]   SL_MAX = SLW'(WINDOW_DEPTH - 1);
	localparam logic [FW-1:0]    FL_MAX = FW'(WINDOW_DEPTH);
	localparam logic [AW-1:0]    WD_A   = AW'(WINDOW_DEPTH);

	logic [VAL_W-1:0]  thr_q;
	logic [MASK_W-1:0] mask_q;

	logic              op_q;
	logic [LEG_W-1:0]  leg_q;
	logic [SW-1:0]     smp_q;

	logic [SLW-1:0]    wp_q   [NS];
	logic [FW-1:0]     fill_q [NS];
	logic              latch_q[NS];

	logic [SW-1:0]     mem [MD];
	logic [SW-1:0]     rd_data_q;
	logic              rdv_q;
	logic              first_q;
	logic [SLW-1:0]    scan_idx_q;
	logic [SW-1:0]     min_q, max_q;
	logic              eval_q;
	logic              push_q;

	logic              in_rng;
	logic [LIW-1:0]    li;
	logic              enabled;
	logic              push_go;
	logic [AW-1:0]     base;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     rd_addr;
	logic [VAL_W-1:0]  span;
	logic              set_now;

	assign in_rng  = {1'b0, leg_q} < NS_V;
	assign li      = leg_q[LIW-1:0];
	assign enabled = in_rng && mask_q[leg_q];
	assign push_go = (op_t'(op_q) == OP_PUSH) && enabled;
	assign base    = AW'(li) * WD_A;
	assign wr_addr = base + AW'(wp_q[li]);
	assign rd_addr = base + AW'(scan_idx_q);
	assign span    = VAL_W'(max_q) - VAL_W'(min_q);
	assign set_now = eval_q && (span > thr_q);

	assign sts.eval_go   = push_go && !latch_q[li];
	assign sts.scan_last = (FW'(scan_idx_q) + FW'(1)) == fill_q[li];
	assign sts.out_busy  = out_valid && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= '0;
			mask_q <= MASK_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_THRESHOLD: thr_q  <= cfg_data;
				CFG_LEG_MASK:  mask_q <= cfg_data[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			leg_q <= leg;
			smp_q <= sample[SW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++) begin
				wp_q[i]    <= '0;
				fill_q[i]  <= '0;
				latch_q[i] <= 1'b0;
			end
			eval_q <= 1'b0;
			push_q <= 1'b0;
		end else begin
			if (cmd.decide) begin
				eval_q <= sts.eval_go;
				push_q <= push_go;
				if (push_go) begin
					wp_q[li] <= (wp_q[li] == SL_MAX) ? '0 : wp_q[li] + SLW'(1);
					if (fill_q[li] != FL_MAX) begin
						fill_q[li] <= fill_q[li] + FW'(1);
					end
				end
				if (op_t'(op_q) == OP_CLEAR && in_rng) begin
					latch_q[li] <= 1'b0;
				end
			end
			if (cmd.emit && set_now && in_rng) begin
				latch_q[li] <= 1'b1;
			end
		end
	end

	// window memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (cmd.decide && push_go) begin
			mem[wr_addr] <= smp_q;
		end
		if (cmd.scan) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdv_q      <= 1'b0;
			first_q    <= 1'b0;
			scan_idx_q <= '0;
		end else begin
			rdv_q <= cmd.scan;
			if (cmd.decide) begin
				scan_idx_q <= '0;
				first_q    <= 1'b1;
			end else if (cmd.scan) begin
				scan_idx_q <= scan_idx_q + SLW'(1);
			end
			if (rdv_q) begin
				first_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdv_q) begin
			if (first_q) begin
				min_q <= rd_data_q;
				max_q <= rd_data_q;
			end else begin
				if (rd_data_q < min_q) min_q <= rd_data_q;
				if (rd_data_q > max_q) max_q <= rd_data_q;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_leg    <= leg_q;
			accepted   <= push_q;
			contact    <= in_rng && (latch_q[li] || set_now);
			window_min <= eval_q ? VAL_W'(min_q) : '0;
			window_max <= eval_q ? VAL_W'(max_q) : '0;
			evaluated  <= eval_q;
		end
	end

endmodule

// ===== sv/windowed_peak_to_peak_contact_detector_unit.sv =====
// Windowed peak-to-peak contact detector: one result item per input item. A push
// item for an enabled leg writes the sample into that leg's ring window; if the
// leg's contact latch is clear the window is walked for min and max, and the latch
// sets when max - min exceeds the threshold. A clear item drops the latch of its leg.
// A push that evaluates walks the n samples in the window after the push (1 to
// WINDOW_DEPTH) one entry a cycle through the single read port of the window memory
// before its result is loaded; every other item skips the walk. The next item is
// accepted while a result still waits.
// Configuration writes take effect at the next edge; make them only while no item
// is in flight.
module windowed_peak_to_peak_contact_detector_unit #(
	parameter int unsigned WINDOW_DEPTH = 16,
	parameter int unsigned LEG_COUNT    = 6,
	parameter int unsigned SAMPLE_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [wppcd_pkg::CFG_IW-1:0] cfg_index,
	input  logic [wppcd_pkg::VAL_W-1:0]  cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         operation,
	input  logic [wppcd_pkg::LEG_W-1:0]  leg,
	input  logic [wppcd_pkg::VAL_W-1:0]  sample,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [wppcd_pkg::LEG_W-1:0]  out_leg,
	output logic                         accepted,
	output logic                         contact,
	output logic [wppcd_pkg::VAL_W-1:0]  window_min,
	output logic [wppcd_pkg::VAL_W-1:0]  window_max,
	output logic                         evaluated
);
	import wppcd_pkg::*;

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	wppcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	wppcd_dp #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.LEG_COUNT    (LEG_COUNT),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.operation  (operation),
		.leg        (leg),
		.sample     (sample),
		.out_stall  (out_stall),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_leg    (out_leg),
		.accepted   (accepted),
		.contact    (contact),
		.window_min (window_min),
		.window_max (window_max),
		.evaluated  (evaluated)
	);

`ifndef SYNTHESIS
	a_emit_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(out_valid && out_stall))
		else $error("result overwritten while stalled");

	a_eval_implies_push: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!evaluated || accepted))
		else $error("evaluated without push");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && evaluated) |-> (window_min <= window_max))
		else $error("window min above max");

	a_accept_starts_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> cmd.decide)
		else $error("accepted item not processed");
`endif

endmodule

// ===== dv/tb_windowed_peak_to_peak_contact_detector_unit.sv =====
// Testbench for the windowed peak-to-peak contact detector: predicting scoreboard, stimulus, checks.
`timescale 1ns / 1ps

module tb_windowed_peak_to_peak_contact_detector_unit;
	import wppcd_pkg::*;

	localparam int unsigned WIN    = 16;
	localparam int unsigned LEGS   = 6;
	localparam int unsigned CLK_NS = 20;
	localparam int unsigned PHASES = 7;
	localparam int unsigned PHASE_ITEMS = 240;
	// mismatch reports stop here so a broken block cannot flood the log
	localparam int unsigned REPORT_CAP = 100;

	typedef struct packed {
		logic [LEG_W-1:0] leg;
		logic             accepted;
		logic             contact;
		logic [VAL_W-1:0] wmin;
		logic [VAL_W-1:0] wmax;
		logic             evaluated;
	} detection_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_IW-1:0]   cfg_index;
	logic [VAL_W-1:0]    cfg_data;
	logic                in_valid;
	logic                in_stall;
	logic                operation;
	logic [LEG_W-1:0]    leg;
	logic [VAL_W-1:0]    sample;
	logic                out_valid;
	logic                out_stall;
	logic [LEG_W-1:0]    out_leg;
	logic                accepted;
	logic                contact;
	logic [VAL_W-1:0]    window_min;
	logic [VAL_W-1:0]    window_max;
	logic                evaluated;

	windowed_peak_to_peak_contact_detector_unit DUT (.*);

	class contact_scoreboard;
		bit [VAL_W-1:0]  threshold;
		bit [MASK_W-1:0] enable_mask;
		bit [VAL_W-1:0]  ring [LEGS][WIN];
		int unsigned     fill [LEGS];
		int unsigned     wr_ptr [LEGS];
		bit              latch [LEGS];
		detection_t      pending_detections [$];
		int unsigned     errors, evals, latch_sets, clears, ignored, full_pushes;

		function new();
			threshold = '0;
			enable_mask = 6'd1;
			foreach (fill[i]) begin
				fill[i] = 0;
				wr_ptr[i] = 0;
				latch[i] = 1'b0;
			end
		endfunction

		function void write_reg(cfg_idx_t idx, bit [VAL_W-1:0] val);
			case (idx)
				CFG_THRESHOLD: threshold = val;
				CFG_LEG_MASK: enable_mask = val[MASK_W-1:0];
				default: ;
			endcase
		endfunction

		// work out the result of an accepted item and queue it
		function void note_item(op_t op, bit [LEG_W-1:0] leg_i, bit [VAL_W-1:0] smp);
			detection_t  d;
			int unsigned span;
			int unsigned i;
			d = '0;
			d.leg = leg_i;
			if (leg_i < LEGS) begin
				if (op == OP_CLEAR) begin
					latch[leg_i] = 1'b0;
					clears++;
				end else if (leg_i < MASK_LEGS && enable_mask[leg_i]) begin
					ring[leg_i][wr_ptr[leg_i]] = smp;
					wr_ptr[leg_i] = (wr_ptr[leg_i] + 1) % WIN;
					if (fill[leg_i] < WIN)
						fill[leg_i]++;
					else
						full_pushes++;
					d.accepted = 1'b1;
					if (!latch[leg_i]) begin
						// slots 0..fill-1 are always the written ones
						d.wmin = ring[leg_i][0];
						d.wmax = ring[leg_i][0];
						for (i = 1; i < fill[leg_i]; i++) begin
							if (ring[leg_i][i] > d.wmax) d.wmax = ring[leg_i][i];
							if (ring[leg_i][i] < d.wmin) d.wmin = ring[leg_i][i];
						end
						d.evaluated = 1'b1;
						evals++;
						span = d.wmax - d.wmin;
						if (span > threshold) begin
							latch[leg_i] = 1'b1;
							latch_sets++;
						end
					end
				end else begin
					ignored++;
				end
				d.contact = latch[leg_i];
			end else begin
				ignored++;
			end
			pending_detections.push_back(d);
		endfunction

		function bit field_ok(string name, int unsigned exp_v, int unsigned act_v);
			if (exp_v == act_v)
				return 1'b1;
			if (errors < REPORT_CAP)
				$display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
			return 1'b0;
		endfunction

		function void check_detection(detection_t got);
			detection_t want;
			bit         ok;
			if (pending_detections.size() == 0) begin
				if (errors < REPORT_CAP)
					$display("%0t: result for leg %0d with no item outstanding", $time, got.leg);
				errors++;
				return;
			end
			want = pending_detections.pop_front();
			ok = 1'b1;
			if (!field_ok("out_leg", want.leg, got.leg)) ok = 1'b0;
			if (!field_ok("accepted", want.accepted, got.accepted)) ok = 1'b0;
			if (!field_ok("contact", want.contact, got.contact)) ok = 1'b0;
			if (!field_ok("window_min", want.wmin, got.wmin)) ok = 1'b0;
			if (!field_ok("window_max", want.wmax, got.wmax)) ok = 1'b0;
			if (!field_ok("evaluated", want.evaluated, got.evaluated)) ok = 1'b0;
			if (!ok)
				errors++;
		endfunction
	endclass

	contact_scoreboard sb;
	bit                quiet;
	int unsigned       sent_items;

	initial begin
		clk = 1'b0;
		forever #(CLK_NS / 2) clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// receiver: random stall, none during the quiet stretch
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 34);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_detection(detection_t'{out_leg, accepted, contact,
				window_min, window_max, evaluated});
	end

	task automatic send(op_t op, logic [LEG_W-1:0] l, logic [VAL_W-1:0] s);
		while (!quiet && $urandom_range(0, 99) < 34) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		operation <= op;
		leg <= l;
		sample <= s;
		do @(posedge clk); while (in_stall);
		sb.note_item(op, l, s);
		sent_items++;
	endtask

	task automatic wait_results_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_detections.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [VAL_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, val);
	endtask

	initial begin
		bit [VAL_W-1:0]  phase_thr [PHASES];
		bit [MASK_W-1:0] phase_mask [PHASES];
		int unsigned     base [LEGS];
		int unsigned     spread [LEGS];
		int unsigned     counted, r, v, p, i;
		bit [VAL_W-1:0]  thr;
		bit [MASK_W-1:0] mask;
		bit [31:0]       junk;
		op_t             op;
		logic [LEG_W-1:0] l;
		logic [VAL_W-1:0] s;

		phase_thr = '{16'd0, 16'hFFFF, 16'd1500, 16'd800, 16'd0, 16'd1, 16'd3000};
		phase_mask = '{6'h3F, 6'h3F, 6'h3F, 6'h2A, 6'h3F, 6'h15, 6'h3F};
		sb = new();
		sent_items = 0;
		quiet = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_THRESHOLD;
		cfg_data = '0;
		in_valid = 1'b0;
		operation = OP_PUSH;
		leg = '0;
		sample = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: threshold 0, only leg 0 enabled
		send(OP_PUSH, 3'd0, 16'h0000);
		send(OP_PUSH, 3'd0, 16'hFFFF);
		send(OP_PUSH, 3'd0, 16'h1234);    // latched: pushed, not evaluated
		send(OP_CLEAR, 3'd0, 16'hFFFF);
		send(OP_PUSH, 3'd1, 16'hFFFF);    // disabled leg
		send(OP_PUSH, 3'd6, 16'h00FF);    // leg out of range
		send(OP_CLEAR, 3'd7, 16'h0000);
		send(OP_PUSH, 3'd7, 16'hFFFF);
		send(OP_CLEAR, 3'd5, 16'hAAAA);   // clear works on a disabled leg
		send(OP_PUSH, 3'd0, 16'h1234);
		wait_results_drained();
		write_reg(CFG_THRESHOLD, 16'hFFFF);
		write_reg(CFG_LEG_MASK, 16'hFFC0);
		send(OP_PUSH, 3'd0, 16'h0005);
		send(OP_PUSH, 3'd3, 16'h5555);
		wait_results_drained();
		write_reg(CFG_LEG_MASK, 16'h003F);
		// full-scale span equals the threshold: no contact
		for (i = 1; i < LEGS; i++) begin
			send(OP_PUSH, i[LEG_W-1:0], 16'hFFFF);
			send(OP_PUSH, i[LEG_W-1:0], 16'h0000);
		end

		for (p = 0; p < PHASES; p++) begin
			wait_results_drained();
			thr = phase_thr[p];
			mask = phase_mask[p];
			if (p == 4) begin
				thr = VAL_W'($urandom_range(0, 4000));
				mask = MASK_W'($urandom_range(1, 63));
			end
			junk = $urandom;
			write_reg(CFG_THRESHOLD, thr);
			write_reg(CFG_LEG_MASK, {junk[VAL_W-MASK_W-1:0], mask});
			quiet = (p == 2);
			for (i = 0; i < LEGS; i++) begin
				base[i] = $urandom_range(0, 60000);
				spread[i] = $urandom_range(0, thr + thr / 4 + 16);
			end
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 4)
					l = 3'd6 + 3'($urandom_range(0, 1));
				else if (r < 85) begin
					do l = LEG_W'($urandom_range(0, LEGS - 1)); while (!mask[l]);
				end else
					l = LEG_W'($urandom_range(0, LEGS - 1));
				if ($urandom_range(0, 99) < 7) begin
					op = OP_CLEAR;
					s = VAL_W'($urandom);
					// new contact episode: fresh level and noise for this leg
					if (l < LEGS) begin
						base[l] = $urandom_range(0, 60000);
						spread[l] = $urandom_range(0, thr + thr / 4 + 16);
					end
				end else begin
					op = OP_PUSH;
					r = $urandom_range(0, 99);
					if (r < 3)
						s = 16'h0000;
					else if (r < 6)
						s = 16'hFFFF;
					else begin
						v = base[l < LEGS ? l : 0] + $urandom_range(0, spread[l < LEGS ? l : 0]);
						s = (v > 32'hFFFF) ? 16'hFFFF : v[VAL_W-1:0];
					end
				end
				send(op, l, s);
				if (l < LEGS && (op == OP_CLEAR || mask[l])) begin
					counted++;
					if (counted == PHASE_ITEMS / 2)
						wait_results_drained();
				end
			end
		end

		quiet = 1'b0;
		wait_results_drained();
		repeat (40) @(posedge clk);
		$display("%0d items over %0d register settings: %0d window evaluations, %0d latch sets",
			sent_items, PHASES + 3, sb.evals, sb.latch_sets);
		$display("%0d latch clears, %0d ignored items, %0d pushes into full windows",
			sb.clears, sb.ignored, sb.full_pushes);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== windowed_peak_to_peak_contact_detector_unit.f =====
sv/wppcd_pkg.sv
sv/wppcd_ctrl.sv
sv/wppcd_dp.sv
sv/windowed_peak_to_peak_contact_detector_unit.sv
dv/tb_windowed_peak_to_peak_contact_detector_unit.sv
